@@ rtl/core/binary_associative_memory_net_unit_assert.svh @@
// Assertion macros for the associative memory block.
// Used by the top level only; needs nothing else.
`ifndef BINARY_ASSOCIATIVE_MEMORY_NET_UNIT_ASSERT_SVH
`define BINARY_ASSOCIATIVE_MEMORY_NET_UNIT_ASSERT_SVH

// same-cycle implication under async reset
`define BAMN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bamn assertion failed");

// next-cycle implication under async reset
`define BAMN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bamn assertion failed");

`endif

@@ rtl/core/bamn_pkg.sv @@
// Shared types and constants for the associative memory block.
// No dependencies.
`default_nettype none
package bamn_pkg;

	localparam int PAT_W = 49;
	localparam int CFG_IDX_W = 8;

	typedef struct packed {
		logic [1:0]         operation;
		logic [PAT_W-1:0]   pattern_a;
		logic [PAT_W-1:0]   pattern_b;
		logic [3:0]         matrix_select;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [15:0] weight_data;
	} in_item_t;

	typedef struct packed {
		logic [PAT_W-1:0]   recalled_a;
		logic [PAT_W-1:0]   recalled_b;
		logic signed [15:0] weight_readback;
		logic               status;
	} out_item_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic upd;
	} mat_ctl_t;

	localparam logic [1:0] OP_RECALL = 2'd0;
	localparam logic [1:0] OP_LEARN  = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam int NMAT = 9;
	localparam logic [3:0] MAT_AC = 4'd0;
	localparam logic [3:0] MAT_BC = 4'd1;
	localparam logic [3:0] MAT_A3 = 4'd2;
	localparam logic [3:0] MAT_B3 = 4'd3;
	localparam logic [3:0] MAT_33 = 4'd4;
	localparam logic [3:0] MAT_31 = 4'd5;
	localparam logic [3:0] MAT_1C = 4'd6;
	localparam logic [3:0] MAT_1A = 4'd7;
	localparam logic [3:0] MAT_1B = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_AC   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_BC   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_HEBB = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRE_DECAY = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_CA3 = 8'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_CA1 = 8'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PASSES    = 8'd7;

	localparam logic [15:0] RST_THRESHOLD = 16'd256;
	localparam logic [15:0] RST_RATE_AC   = 16'd13;
	localparam logic [15:0] RST_RATE_BC   = 16'd13;
	localparam logic [15:0] RST_RATE_HEBB = 16'd256;
	localparam logic [15:0] RST_PRE_DECAY = 16'd26;
	localparam logic [15:0] RST_DECAY_CA3 = 16'd8;
	localparam logic [15:0] RST_DECAY_CA1 = 16'd8;
	localparam logic [3:0]  RST_PASSES    = 4'd5;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RUN  = 9'b000000010,
		ST_WAIT = 9'b000000100,
		ST_UPD  = 9'b000001000,
		ST_UGAP = 9'b000010000,
		ST_HWR  = 9'b000100000,
		ST_HRD  = 9'b001000000,
		ST_HRES = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	typedef enum logic [5:0] {
		PH_F1 = 6'b000001,
		PH_F2 = 6'b000010,
		PH_F3 = 6'b000100,
		PH_F4 = 6'b001000,
		PH_RA = 6'b010000,
		PH_RB = 6'b100000
	} phase_t;

endpackage
`default_nettype wire

@@ rtl/core/binary_associative_memory_net_unit.sv @@
// Binary-neuron associative memory: nine Q7.8 weight matrices in RAM, threshold neurons.
// Depends on bamn_pkg, bamn_mat, bamn_lane, bamn_merge and the assertion header.
//
// For each neuron, up to three lanes read one weight each per cycle from their matrix
// RAMs, then the merge stage decides the bit. A recall sweeps CA3 from A and B, CA3
// from CA3, CA1 from CA3, C from A, B and CA1, then A and B from C and CA1. A learn
// adds per pass one forward sweep and an update sweep in which all nine matrices
// read-modify-write one weight per cycle in parallel. A weight write passes through
// states HWR and FIN, a weight read through HRD, HRES and FIN. Weights are undefined
// until written; no clearing pass exists.
`default_nettype none
`include "binary_associative_memory_net_unit_assert.svh"
module binary_associative_memory_net_unit #(
	parameter int A_NEURONS   = 49,
	parameter int B_NEURONS   = 49,
	parameter int C_NEURONS   = 49,
	parameter int CA1_NEURONS = 32,
	parameter int CA3_NEURONS = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire bamn_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output bamn_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bamn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [15:0]                        cfg_data
);
	import bamn_pkg::*;

	localparam int WB    = WEIGHT_BITS;
	localparam int ACC_W = WB + 7;
	localparam int RW    = WB + 16;
	localparam int JN_F1 = (A_NEURONS > B_NEURONS) ? A_NEURONS : B_NEURONS;
	localparam int JN_F4 = (JN_F1 > CA1_NEURONS) ? JN_F1 : CA1_NEURONS;
	localparam int JN_R  = (C_NEURONS > CA1_NEURONS) ? C_NEURONS : CA1_NEURONS;
	localparam int MROWS [NMAT] = '{A_NEURONS, B_NEURONS, A_NEURONS, B_NEURONS,
		CA3_NEURONS, CA3_NEURONS, CA1_NEURONS, CA1_NEURONS, CA1_NEURONS};
	localparam int MCOLS [NMAT] = '{C_NEURONS, C_NEURONS, CA3_NEURONS, CA3_NEURONS,
		CA3_NEURONS, CA1_NEURONS, C_NEURONS, A_NEURONS, B_NEURONS};
	localparam logic signed [RW-1:0] HI16 = {{(RW-15){1'b0}}, {15{1'b1}}};

	state_t state_q;
	phase_t phase_q;
	logic [5:0]  i_q, j_q, r_q, c_q;
	logic [3:0]  pass_q;
	logic        learn_q;
	in_item_t    item_q;
	logic [63:0] act_ca3_q, act_ca1_q, act_c_q, res_a_q, res_b_q;
	logic signed [15:0] rb_q;
	logic        st_q;
	out_item_t   out_q;
	out_item_t   res_d;
	logic        out_valid_q;
	logic        fin_go;

	logic [15:0] thr_q, rate_ac_q, rate_bc_q, rate_hebb_q, pre_decay_q;
	logic [15:0] decay_ca3_q, decay_ca1_q;
	logic [3:0]  passes_q;

	logic        vld_s1, last_s1, done_s2, done_s3;
	logic [2:0]  lact, lact_s1;
	logic [5:0]  jn_last, in_last;
	logic [63:0] a_ext, b_ext;
	logic        fire_s3;
	logic        bad;

	mat_ctl_t    mctl [NMAT];
	logic [5:0]  mrow [NMAT];
	logic [5:0]  mcol [NMAT];
	logic [63:0] mpre [NMAT];
	logic [63:0] mpost [NMAT];
	logic [15:0] mgain [NMAT];
	logic [15:0] mpdec [NMAT];
	logic [15:0] mcdec [NMAT];
	logic signed [WB-1:0] mrdata [NMAT];
	logic signed [WB-1:0] ldata [3];
	logic signed [ACC_W-1:0] lacc [3];
	logic signed [WB-1:0] sel_rdata;
	logic signed [RW-1:0] rb_ext;
	logic signed [15:0]   rb_sat;

	assign a_ext = 64'(item_q.pattern_a);
	assign b_ext = 64'(item_q.pattern_b);
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= RST_THRESHOLD;
			rate_ac_q   <= RST_RATE_AC;
			rate_bc_q   <= RST_RATE_BC;
			rate_hebb_q <= RST_RATE_HEBB;
			pre_decay_q <= RST_PRE_DECAY;
			decay_ca3_q <= RST_DECAY_CA3;
			decay_ca1_q <= RST_DECAY_CA1;
			passes_q    <= RST_PASSES;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q       <= cfg_data;
				CFG_RATE_AC:   rate_ac_q   <= cfg_data;
				CFG_RATE_BC:   rate_bc_q   <= cfg_data;
				CFG_RATE_HEBB: rate_hebb_q <= cfg_data;
				CFG_PRE_DECAY: pre_decay_q <= cfg_data;
				CFG_DECAY_CA3: decay_ca3_q <= cfg_data;
				CFG_DECAY_CA1: decay_ca1_q <= cfg_data;
				CFG_PASSES:    passes_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// index check for host access
	always_comb begin
		bad = 1'b1;
		for (int m = 0; m < NMAT; m++) begin
			if (in_data.matrix_select == 4'(m)) begin
				bad = ({1'b0, in_data.row_index} >= 7'(MROWS[m]))
					|| ({1'b0, in_data.col_index} >= 7'(MCOLS[m]));
			end
		end
	end

	always_comb begin
		case (phase_q)
			PH_F1: begin
				jn_last = 6'(JN_F1 - 1);
				in_last = 6'(CA3_NEURONS - 1);
			end
			PH_F2: begin
				jn_last = 6'(CA3_NEURONS - 1);
				in_last = 6'(CA3_NEURONS - 1);
			end
			PH_F3: begin
				jn_last = 6'(CA3_NEURONS - 1);
				in_last = 6'(CA1_NEURONS - 1);
			end
			PH_F4: begin
				jn_last = 6'(JN_F4 - 1);
				in_last = 6'(C_NEURONS - 1);
			end
			PH_RA: begin
				jn_last = 6'(JN_R - 1);
				in_last = 6'(A_NEURONS - 1);
			end
			PH_RB: begin
				jn_last = 6'(JN_R - 1);
				in_last = 6'(B_NEURONS - 1);
			end
			default: begin
				jn_last = '0;
				in_last = '0;
			end
		endcase
	end

	// matrix port control, lane source bits and update terms
	always_comb begin
		lact = '0;
		for (int m = 0; m < NMAT; m++) begin
			mctl[m] = '0;
			mrow[m] = '0;
			mcol[m] = '0;
		end
		case (state_q)
			ST_HWR: begin
				mctl[item_q.matrix_select].wr = 1'b1;
				mrow[item_q.matrix_select] = item_q.row_index;
				mcol[item_q.matrix_select] = item_q.col_index;
			end
			ST_HRD: begin
				mctl[item_q.matrix_select].rd = 1'b1;
				mrow[item_q.matrix_select] = item_q.row_index;
				mcol[item_q.matrix_select] = item_q.col_index;
			end
			ST_UPD: begin
				for (int m = 0; m < NMAT; m++) begin
					mctl[m].upd = 1'b1;
					mrow[m] = r_q;
					mcol[m] = c_q;
				end
			end
			ST_RUN: begin
				case (phase_q)
					PH_F1: begin
						mctl[MAT_A3].rd = 1'b1; mrow[MAT_A3] = j_q; mcol[MAT_A3] = i_q;
						mctl[MAT_B3].rd = 1'b1; mrow[MAT_B3] = j_q; mcol[MAT_B3] = i_q;
						lact[0] = a_ext[j_q] && ({1'b0, j_q} < 7'(A_NEURONS));
						lact[1] = b_ext[j_q] && ({1'b0, j_q} < 7'(B_NEURONS));
					end
					PH_F2: begin
						mctl[MAT_33].rd = 1'b1; mrow[MAT_33] = i_q; mcol[MAT_33] = j_q;
						lact[0] = act_ca3_q[j_q];
					end
					PH_F3: begin
						mctl[MAT_31].rd = 1'b1; mrow[MAT_31] = j_q; mcol[MAT_31] = i_q;
						lact[0] = act_ca3_q[j_q];
					end
					PH_F4: begin
						mctl[MAT_AC].rd = 1'b1; mrow[MAT_AC] = j_q; mcol[MAT_AC] = i_q;
						mctl[MAT_BC].rd = 1'b1; mrow[MAT_BC] = j_q; mcol[MAT_BC] = i_q;
						mctl[MAT_1C].rd = 1'b1; mrow[MAT_1C] = j_q; mcol[MAT_1C] = i_q;
						lact[0] = a_ext[j_q] && ({1'b0, j_q} < 7'(A_NEURONS));
						lact[1] = b_ext[j_q] && ({1'b0, j_q} < 7'(B_NEURONS));
						lact[2] = act_ca1_q[j_q];
					end
					PH_RA: begin
						mctl[MAT_AC].rd = 1'b1; mrow[MAT_AC] = i_q; mcol[MAT_AC] = j_q;
						mctl[MAT_1A].rd = 1'b1; mrow[MAT_1A] = j_q; mcol[MAT_1A] = i_q;
						lact[0] = act_c_q[j_q];
						lact[1] = act_ca1_q[j_q];
					end
					PH_RB: begin
						mctl[MAT_BC].rd = 1'b1; mrow[MAT_BC] = i_q; mcol[MAT_BC] = j_q;
						mctl[MAT_1B].rd = 1'b1; mrow[MAT_1B] = j_q; mcol[MAT_1B] = i_q;
						lact[0] = act_c_q[j_q];
						lact[1] = act_ca1_q[j_q];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		mpre[MAT_AC] = a_ext;     mpost[MAT_AC] = act_c_q;
		mpre[MAT_BC] = b_ext;     mpost[MAT_BC] = act_c_q;
		mpre[MAT_A3] = a_ext;     mpost[MAT_A3] = act_ca3_q;
		mpre[MAT_B3] = b_ext;     mpost[MAT_B3] = act_ca3_q;
		mpre[MAT_33] = act_ca3_q; mpost[MAT_33] = act_ca3_q;
		mpre[MAT_31] = act_ca3_q; mpost[MAT_31] = act_ca1_q;
		mpre[MAT_1C] = act_ca1_q; mpost[MAT_1C] = act_c_q;
		mpre[MAT_1A] = act_ca1_q; mpost[MAT_1A] = a_ext;
		mpre[MAT_1B] = act_ca1_q; mpost[MAT_1B] = b_ext;
		mgain[MAT_AC] = rate_ac_q; mpdec[MAT_AC] = '0; mcdec[MAT_AC] = '0;
		mgain[MAT_BC] = rate_bc_q; mpdec[MAT_BC] = '0; mcdec[MAT_BC] = '0;
		mgain[MAT_A3] = rate_hebb_q; mpdec[MAT_A3] = pre_decay_q; mcdec[MAT_A3] = decay_ca3_q;
		mgain[MAT_B3] = rate_hebb_q; mpdec[MAT_B3] = pre_decay_q; mcdec[MAT_B3] = decay_ca3_q;
		mgain[MAT_33] = rate_hebb_q; mpdec[MAT_33] = '0; mcdec[MAT_33] = decay_ca3_q;
		mgain[MAT_31] = rate_hebb_q; mpdec[MAT_31] = pre_decay_q; mcdec[MAT_31] = decay_ca1_q;
		mgain[MAT_1C] = rate_hebb_q; mpdec[MAT_1C] = '0; mcdec[MAT_1C] = decay_ca1_q;
		mgain[MAT_1A] = rate_hebb_q; mpdec[MAT_1A] = '0; mcdec[MAT_1A] = decay_ca1_q;
		mgain[MAT_1B] = rate_hebb_q; mpdec[MAT_1B] = '0; mcdec[MAT_1B] = decay_ca1_q;
	end

	for (genvar m = 0; m < NMAT; m++) begin : g_mat
		bamn_mat #(.ROWS(MROWS[m]), .COLS(MCOLS[m]), .WB(WB)) u_mat (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (mctl[m]),
			.row     (mrow[m]),
			.col     (mcol[m]),
			.wdata   (item_q.weight_data),
			.pre     (mpre[m]),
			.post    (mpost[m]),
			.gain    (mgain[m]),
			.pre_dec (mpdec[m]),
			.cdec    (mcdec[m]),
			.rdata   (mrdata[m])
		);
	end

	// lane data follows the phase, which holds until the neuron is decided
	always_comb begin
		ldata[0] = '0;
		ldata[1] = '0;
		ldata[2] = mrdata[MAT_1C];
		case (phase_q)
			PH_F1: begin
				ldata[0] = mrdata[MAT_A3];
				ldata[1] = mrdata[MAT_B3];
			end
			PH_F2: ldata[0] = mrdata[MAT_33];
			PH_F3: ldata[0] = mrdata[MAT_31];
			PH_F4: begin
				ldata[0] = mrdata[MAT_AC];
				ldata[1] = mrdata[MAT_BC];
			end
			PH_RA: begin
				ldata[0] = mrdata[MAT_AC];
				ldata[1] = mrdata[MAT_1A];
			end
			PH_RB: begin
				ldata[0] = mrdata[MAT_BC];
				ldata[1] = mrdata[MAT_1B];
			end
			default: ;
		endcase
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		bamn_lane #(.WB(WB), .ACC_W(ACC_W)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (done_s2),
			.en     (vld_s1 && lact_s1[k]),
			.data   (ldata[k]),
			.acc_q  (lacc[k])
		);
	end

	bamn_merge #(.ACC_W(ACC_W)) u_merge (
		.clk     (clk),
		.lane0   (lacc[0]),
		.lane1   (lacc[1]),
		.lane2   (lacc[2]),
		.thr     ($signed(thr_q)),
		.fire_s3 (fire_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			lact_s1 <= '0;
			done_s2 <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			vld_s1  <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && (j_q == jn_last);
			lact_s1 <= lact;
			done_s2 <= last_s1;
			done_s3 <= done_s2;
		end
	end

	// readback saturation to 16 bits
	assign sel_rdata = mrdata[item_q.matrix_select];
	assign rb_ext = {{16{sel_rdata[WB-1]}}, sel_rdata};
	always_comb begin
		if (rb_ext > HI16) begin
			rb_sat = 16'sh7fff;
		end else if (rb_ext < ~HI16) begin
			rb_sat = -16'sh8000;
		end else begin
			rb_sat = rb_ext[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_F1;
			i_q         <= '0;
			j_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
			pass_q      <= '0;
			learn_q     <= 1'b0;
			item_q      <= '0;
			act_ca3_q   <= '0;
			act_ca1_q   <= '0;
			act_c_q     <= '0;
			res_a_q     <= '0;
			res_b_q     <= '0;
			rb_q        <= '0;
			st_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						i_q    <= '0;
						j_q    <= '0;
						pass_q <= '0;
						rb_q   <= '0;
						case (in_data.operation)
							OP_RECALL: begin
								st_q    <= 1'b0;
								learn_q <= 1'b0;
								phase_q <= PH_F1;
								state_q <= ST_RUN;
							end
							OP_LEARN: begin
								st_q    <= 1'b0;
								learn_q <= 1'b1;
								phase_q <= (passes_q == 4'd0) ? PH_RA : PH_F1;
								state_q <= ST_RUN;
							end
							default: begin
								if (bad || in_data.matrix_select > MAT_1B) begin
									st_q    <= 1'b1;
									state_q <= ST_FIN;
								end else if (in_data.operation == OP_WRITE) begin
									st_q    <= 1'b0;
									state_q <= ST_HWR;
								end else begin
									st_q    <= 1'b0;
									state_q <= ST_HRD;
								end
							end
						endcase
					end
				end
				ST_RUN: begin
					if (j_q == jn_last) begin
						j_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						j_q <= j_q + 6'd1;
					end
				end
				ST_WAIT: begin
					if (done_s3) begin
						case (phase_q)
							PH_F1, PH_F2: act_ca3_q[i_q] <= fire_s3;
							PH_F3: act_ca1_q[i_q] <= fire_s3;
							PH_F4: act_c_q[i_q] <= fire_s3;
							PH_RA: res_a_q[i_q] <= fire_s3;
							PH_RB: res_b_q[i_q] <= fire_s3;
							default: ;
						endcase
						if (i_q == in_last) begin
							i_q <= '0;
							case (phase_q)
								PH_F1: begin
									phase_q <= PH_F2;
									state_q <= ST_RUN;
								end
								PH_F2: begin
									phase_q <= PH_F3;
									state_q <= ST_RUN;
								end
								PH_F3: begin
									phase_q <= PH_F4;
									state_q <= ST_RUN;
								end
								PH_F4: begin
									if (learn_q) begin
										r_q     <= '0;
										c_q     <= '0;
										state_q <= ST_UPD;
									end else begin
										phase_q <= PH_RA;
										state_q <= ST_RUN;
									end
								end
								PH_RA: begin
									phase_q <= PH_RB;
									state_q <= ST_RUN;
								end
								default: state_q <= ST_FIN;
							endcase
						end else begin
							i_q     <= i_q + 6'd1;
							state_q <= ST_RUN;
						end
					end
				end
				ST_UPD: begin
					c_q <= c_q + 6'd1;
					if (c_q == 6'd63) begin
						r_q <= r_q + 6'd1;
						if (r_q == 6'd63) begin
							state_q <= ST_UGAP;
						end
					end
				end
				ST_UGAP: begin
					state_q <= ST_RUN;
					if (pass_q + 4'd1 == passes_q) begin
						phase_q <= PH_RA;
					end else begin
						pass_q  <= pass_q + 4'd1;
						phase_q <= PH_F1;
					end
				end
				ST_HWR: state_q <= ST_FIN;
				ST_HRD: state_q <= ST_HRES;
				ST_HRES: begin
					rb_q    <= rb_sat;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result beat
	always_comb begin
		res_d = '0;
		if (item_q.operation == OP_RECALL || item_q.operation == OP_LEARN) begin
			res_d.recalled_a = PAT_W'(res_a_q);
			res_d.recalled_b = PAT_W'(res_b_q);
		end else begin
			res_d.weight_readback = rb_q;
			res_d.status          = st_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q <= res_d;
		end
	end

	`BAMN_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && in_ready, state_q != ST_IDLE)
	`BAMN_ASSERT_IMP(a_done_in_wait, clk, arst_n, done_s3, state_q == ST_WAIT)
	`BAMN_ASSERT_IMP(a_j_bound, clk, arst_n, state_q == ST_RUN, j_q <= jn_last)
	`BAMN_ASSERT_NXT(a_fin_beat, clk, arst_n, state_q == ST_FIN && !out_valid_q, out_valid_q)

endmodule
`default_nettype wire

@@ rtl/core/bamn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bamn_ram #(
	parameter int W = 16,
	parameter int D = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(D > 1 ? D : 2)-1:0] waddr,
	input  wire logic [W-1:0]                     wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(D > 1 ? D : 2)-1:0] raddr,
	output logic      [W-1:0]                     rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/bamn_mat.sv @@
// One weight matrix: RAM plus host write and saturating Hebbian update path.
// Depends on bamn_pkg and bamn_ram.
`default_nettype none
module bamn_mat #(
	parameter int ROWS = 32,
	parameter int COLS = 32,
	parameter int WB   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bamn_pkg::mat_ctl_t ctl,
	input  wire logic [5:0]         row,
	input  wire logic [5:0]         col,
	input  wire logic signed [15:0] wdata,
	input  wire logic [63:0]        pre,
	input  wire logic [63:0]        post,
	input  wire logic [15:0]        gain,
	input  wire logic [15:0]        pre_dec,
	input  wire logic [15:0]        cdec,
	output logic signed [WB-1:0]    rdata
);
	import bamn_pkg::*;

	localparam int DEPTH = ROWS * COLS;
	localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
	localparam int SW = WB + 19;
	localparam logic signed [SW-1:0] HI = {{(SW-WB+1){1'b0}}, {(WB-1){1'b1}}};
	localparam logic signed [SW-1:0] LO = ~HI;

	logic          in_range;
	logic [11:0]   lin;
	logic [AW-1:0] addr;
	logic signed [17:0] d;
	logic          upd_s1;
	logic [AW-1:0] addr_s1;
	logic signed [17:0] d_s1;
	logic signed [SW-1:0] upd_sum, wr_ext, wsel;
	logic [WB-1:0] wsat;
	logic          we;
	logic [AW-1:0] waddr;
	logic [WB-1:0] ram_q;

	assign in_range = ({1'b0, row} < 7'(ROWS)) && ({1'b0, col} < 7'(COLS));
	assign lin  = 12'(row) * 12'(COLS) + 12'(col);
	assign addr = AW'(lin);

	always_comb begin
		d = -$signed({2'b00, cdec});
		if (pre[row]) begin
			d = d - $signed({2'b00, pre_dec});
			if (post[col]) begin
				d = d + $signed({2'b00, gain});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
		end else begin
			upd_s1 <= ctl.upd && in_range;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		d_s1    <= d;
	end

	assign upd_sum = {{19{rdata[WB-1]}}, rdata} + {{(SW-18){d_s1[17]}}, d_s1};
	assign wr_ext  = {{(SW-16){wdata[15]}}, wdata};
	assign wsel    = upd_s1 ? upd_sum : wr_ext;

	always_comb begin
		if (wsel > HI) begin
			wsat = HI[WB-1:0];
		end else if (wsel < LO) begin
			wsat = LO[WB-1:0];
		end else begin
			wsat = wsel[WB-1:0];
		end
	end

	assign we    = upd_s1 || (ctl.wr && in_range);
	assign waddr = upd_s1 ? addr_s1 : addr;

	bamn_ram #(.W(WB), .D(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wsat),
		.re    (ctl.rd || ctl.upd),
		.raddr (addr),
		.rdata (ram_q)
	);

	assign rdata = $signed(ram_q);
endmodule
`default_nettype wire

@@ rtl/core/bamn_lane.sv @@
// Accumulator lane: adds the weight read this beat when its source is active.
// Depends on nothing.
`default_nettype none
module bamn_lane #(
	parameter int WB    = 16,
	parameter int ACC_W = 23
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                clr,
	input  wire logic                en,
	input  wire logic signed [WB-1:0] data,
	output logic signed [ACC_W-1:0]  acc_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= acc_q + {{(ACC_W-WB){data[WB-1]}}, data};
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/bamn_merge.sv @@
// Merge stage: sums the lane totals, subtracts the threshold, registers the fire bit.
// Depends on nothing.
`default_nettype none
module bamn_merge #(
	parameter int ACC_W = 23
) (
	input  wire logic                   clk,
	input  wire logic signed [ACC_W-1:0] lane0,
	input  wire logic signed [ACC_W-1:0] lane1,
	input  wire logic signed [ACC_W-1:0] lane2,
	input  wire logic signed [15:0]      thr,
	output logic                        fire_s3
);
	localparam int MW = ACC_W + 3;

	logic signed [MW-1:0] sum;

	assign sum = {{3{lane0[ACC_W-1]}}, lane0} + {{3{lane1[ACC_W-1]}}, lane1}
		+ {{3{lane2[ACC_W-1]}}, lane2} - {{(MW-16){thr[15]}}, thr};

	always_ff @(posedge clk) begin
		fire_s3 <= !sum[MW-1];
	end
endmodule
`default_nettype wire

@@ dv/binary_associative_memory_net_unit_tb.sv @@
// Self-checking bench for binary_associative_memory_net_unit: fills all weights, then runs
// directed and random recall/learn/weight-access beats against an in-bench neuron predictor.
// Depends on bamn_pkg and the DUT only.
`timescale 1ns / 1ps

class assoc_mem_scoreboard;
	localparam int NA = 49, NB = 49, NC = 49, N1 = 32, N3 = 32;
	longint wt[9][4096];
	int rows[9] = '{NA, NB, NA, NB, N3, N3, N1, N1, N1};
	int cols[9] = '{NC, NC, N3, N3, N3, N1, NC, NA, NB};
	bit [63:0] ca3, ca1, cc;
	logic signed [15:0] thr = 256;
	longint rate_ac = 13, rate_bc = 13, rate_hebb = 256, pre_dec = 26;
	longint dec3 = 8, dec1 = 8, passes = 5;
	bamn_pkg::out_item_t expq[$];
	int errors;

	function bit fires(longint s);
		return s - longint'(thr) >= 0;
	endfunction

	function longint sat16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function void set_reg(logic [7:0] idx, logic [15:0] d);
		case (idx)
			bamn_pkg::CFG_THRESHOLD: thr = d;
			bamn_pkg::CFG_RATE_AC:   rate_ac = longint'(d);
			bamn_pkg::CFG_RATE_BC:   rate_bc = longint'(d);
			bamn_pkg::CFG_RATE_HEBB: rate_hebb = longint'(d);
			bamn_pkg::CFG_PRE_DECAY: pre_dec = longint'(d);
			bamn_pkg::CFG_DECAY_CA3: dec3 = longint'(d);
			bamn_pkg::CFG_DECAY_CA1: dec1 = longint'(d);
			bamn_pkg::CFG_PASSES:    passes = longint'(d[3:0]);
			default: ;
		endcase
	endfunction

	function void fwd(bit [63:0] a, bit [63:0] b);
		longint s;
		ca3 = 0;
		for (int i = 0; i < N3; i++) begin
			s = 0;
			for (int j = 0; j < NA; j++) if (a[j]) s += wt[bamn_pkg::MAT_A3][j*N3+i];
			for (int j = 0; j < NB; j++) if (b[j]) s += wt[bamn_pkg::MAT_B3][j*N3+i];
			if (fires(s)) ca3[i] = 1;
		end
		for (int i = 0; i < N3; i++) begin
			s = 0;
			for (int j = 0; j < N3; j++) if (ca3[j]) s += wt[bamn_pkg::MAT_33][i*N3+j];
			ca3[i] = fires(s);
		end
		ca1 = 0;
		for (int i = 0; i < N1; i++) begin
			s = 0;
			for (int j = 0; j < N3; j++) if (ca3[j]) s += wt[bamn_pkg::MAT_31][j*N1+i];
			if (fires(s)) ca1[i] = 1;
		end
		cc = 0;
		for (int i = 0; i < NC; i++) begin
			s = 0;
			for (int j = 0; j < NA; j++) if (a[j]) s += wt[bamn_pkg::MAT_AC][j*NC+i];
			for (int j = 0; j < NB; j++) if (b[j]) s += wt[bamn_pkg::MAT_BC][j*NC+i];
			for (int j = 0; j < N1; j++) if (ca1[j]) s += wt[bamn_pkg::MAT_1C][j*NC+i];
			if (fires(s)) cc[i] = 1;
		end
	endfunction

	function bit [48:0] recall_layer(logic [3:0] mc, logic [3:0] m1, int n);
		bit [48:0] r;
		longint s;
		r = 0;
		for (int i = 0; i < n; i++) begin
			s = 0;
			for (int j = 0; j < NC; j++) if (cc[j]) s += wt[mc][i*NC+j];
			for (int j = 0; j < N1; j++) if (ca1[j]) s += wt[m1][j*n+i];
			if (fires(s)) r[i] = 1;
		end
		return r;
	endfunction

	function void hebb(logic [3:0] m, bit [63:0] pre, bit [63:0] post, longint g, longint pd,
			longint cd);
		longint d;
		for (int i = 0; i < rows[m]; i++)
			for (int j = 0; j < cols[m]; j++) begin
				d = -cd;
				if (pre[i]) begin
					d -= pd;
					if (post[j]) d += g;
				end
				wt[m][i*cols[m]+j] = sat16(wt[m][i*cols[m]+j] + d);
			end
	endfunction

	function void note(bamn_pkg::in_item_t it);
		bamn_pkg::out_item_t o;
		bit [63:0] a, b;
		logic [3:0] m;
		longint z;
		o = '0;
		z = 0;
		a = 64'(it.pattern_a);
		b = 64'(it.pattern_b);
		m = it.matrix_select;
		if (it.operation == bamn_pkg::OP_RECALL || it.operation == bamn_pkg::OP_LEARN) begin
			if (it.operation == bamn_pkg::OP_RECALL) fwd(a, b);
			else for (int p = 0; p < passes; p++) begin
				fwd(a, b);
				hebb(bamn_pkg::MAT_AC, a, cc, rate_ac, z, z);
				hebb(bamn_pkg::MAT_BC, b, cc, rate_bc, z, z);
				hebb(bamn_pkg::MAT_A3, a, ca3, rate_hebb, pre_dec, dec3);
				hebb(bamn_pkg::MAT_B3, b, ca3, rate_hebb, pre_dec, dec3);
				hebb(bamn_pkg::MAT_33, ca3, ca3, rate_hebb, z, dec3);
				hebb(bamn_pkg::MAT_31, ca3, ca1, rate_hebb, pre_dec, dec1);
				hebb(bamn_pkg::MAT_1C, ca1, cc, rate_hebb, z, dec1);
				hebb(bamn_pkg::MAT_1A, ca1, a, rate_hebb, z, dec1);
				hebb(bamn_pkg::MAT_1B, ca1, b, rate_hebb, z, dec1);
			end
			o.recalled_a = recall_layer(bamn_pkg::MAT_AC, bamn_pkg::MAT_1A, NA);
			o.recalled_b = recall_layer(bamn_pkg::MAT_BC, bamn_pkg::MAT_1B, NB);
		end else if (m > 4'd8 || it.row_index >= rows[m] || it.col_index >= cols[m]) begin
			o.status = 1'b1;
		end else if (it.operation == bamn_pkg::OP_WRITE) begin
			wt[m][it.row_index*cols[m]+it.col_index] = longint'(it.weight_data);
		end else begin
			o.weight_readback = 16'(wt[m][it.row_index*cols[m]+it.col_index]);
		end
		expq.push_back(o);
	endfunction

	function void check(bamn_pkg::out_item_t o);
		bamn_pkg::out_item_t e;
		if (expq.size() == 0) begin
			$error("unexpected result beat %h", o);
			errors++;
			return;
		end
		e = expq.pop_front();
		if (o.recalled_a !== e.recalled_a) begin
			$error("recalled_a exp %h got %h", e.recalled_a, o.recalled_a); errors++;
		end
		if (o.recalled_b !== e.recalled_b) begin
			$error("recalled_b exp %h got %h", e.recalled_b, o.recalled_b); errors++;
		end
		if (o.weight_readback !== e.weight_readback) begin
			$error("weight_readback exp %0d got %0d", e.weight_readback, o.weight_readback);
			errors++;
		end
		if (o.status !== e.status) begin
			$error("status exp %0b got %0b", e.status, o.status); errors++;
		end
	endfunction
endclass

module binary_associative_memory_net_unit_tb;
	import bamn_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_ready = 0, cfg_valid = 0;
	logic in_ready, out_valid, cfg_ready;
	in_item_t in_data = '0;
	out_item_t out_data;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int hold_cycles = 0;
	bit calm = 0;
	assoc_mem_scoreboard sb = new();

	binary_associative_memory_net_unit DUT (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check(out_data);

	initial begin
		int stall, r;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 0;
				hold_cycles--;
			end else if (stall > 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
				r = $urandom_range(0, 99);
				if (!calm && r < 10) stall = $urandom_range(1, 3);
				else if (!calm && r < 12) stall = $urandom_range(15, 60);
			end
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send(in_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
		drain();
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_op(logic [1:0] op, logic [48:0] a, logic [48:0] b, logic [3:0] m,
			logic [5:0] row, logic [5:0] col, logic [15:0] d);
		in_item_t it;
		it = '{op, a, b, m, row, col, d};
		send(it);
	endtask

	function logic [48:0] rand_pat();
		return 49'({$urandom, $urandom});
	endfunction

	function in_item_t rand_item();
		in_item_t it;
		int r, m;
		r = $urandom_range(0, 99);
		it.pattern_a = rand_pat();
		it.pattern_b = rand_pat();
		it.weight_data = ($urandom_range(0, 9) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 600) - 300);
		m = $urandom_range(0, 8);
		it.matrix_select = 4'(m);
		it.row_index = 6'($urandom_range(0, sb.rows[m] - 1));
		it.col_index = 6'($urandom_range(0, sb.cols[m] - 1));
		if ($urandom_range(0, 9) == 0) begin
			it.matrix_select = 4'($urandom);
			it.row_index = 6'($urandom);
			it.col_index = 6'($urandom);
		end
		it.operation = r < 55 ? OP_READ : r < 80 ? OP_WRITE : r < 93 ? OP_RECALL : OP_LEARN;
		return it;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// load every weight before any recall touches it
		calm = 1;
		for (int m = 0; m < 9; m++)
			for (int i = 0; i < sb.rows[m]; i++)
				for (int j = 0; j < sb.cols[m]; j++)
					send_op(OP_WRITE, '0, '0, 4'(m), 6'(i), 6'(j),
						16'($urandom_range(0, 400) - 200));
		calm = 0;

		send_op(OP_WRITE, '0, '0, MAT_AC, 6'd0, 6'd0, 16'sh7fff);
		send_op(OP_READ, '0, '0, MAT_AC, 6'd0, 6'd0, 16'd0);
		send_op(OP_WRITE, '0, '0, MAT_1B, 6'd31, 6'd48, 16'sh8000);
		send_op(OP_READ, '0, '0, MAT_1B, 6'd31, 6'd48, 16'd0);
		send_op(OP_READ, '0, '0, 4'd9, 6'd0, 6'd0, 16'd0);
		send_op(OP_WRITE, '0, '0, 4'd15, 6'd63, 6'd63, 16'h1234);
		send_op(OP_READ, '0, '0, MAT_AC, 6'd49, 6'd0, 16'd0);
		send_op(OP_READ, '0, '0, MAT_A3, 6'd0, 6'd32, 16'd0);
		send_op(OP_WRITE, '0, '0, MAT_33, 6'd32, 6'd0, 16'h0100);
		send_op(OP_RECALL, '1, '0, 4'd0, 6'd0, 6'd0, 16'd0);
		send_op(OP_RECALL, '0, '1, 4'd0, 6'd0, 6'd0, 16'd0);
		send_op(OP_RECALL, '0, '0, 4'd0, 6'd0, 6'd0, 16'd0);
		send_op(OP_WRITE, '0, '0, MAT_AC, 6'd0, 6'd0, 16'sd50);
		send_op(OP_WRITE, '0, '0, MAT_1B, 6'd31, 6'd48, -16'sd50);
		set_reg(CFG_THRESHOLD, 16'h8000);
		send_op(OP_RECALL, rand_pat(), rand_pat(), 4'd0, 6'd0, 6'd0, 16'd0);
		set_reg(CFG_THRESHOLD, 16'h7fff);
		send_op(OP_RECALL, rand_pat(), rand_pat(), 4'd0, 6'd0, 6'd0, 16'd0);
		set_reg(CFG_THRESHOLD, 16'd0);
		set_reg(CFG_PASSES, 16'd0);
		send_op(OP_LEARN, rand_pat(), rand_pat(), 4'd0, 6'd0, 6'd0, 16'd0);
		set_reg(CFG_PASSES, 16'd1);
		set_reg(CFG_RATE_AC, 16'hffff);
		set_reg(CFG_RATE_BC, 16'd0);
		set_reg(CFG_RATE_HEBB, 16'hffff);
		set_reg(CFG_PRE_DECAY, 16'hffff);
		set_reg(CFG_DECAY_CA3, 16'd0);
		set_reg(CFG_DECAY_CA1, 16'hffff);
		send_op(OP_LEARN, rand_pat(), rand_pat(), 4'd0, 6'd0, 6'd0, 16'd0);
		set_reg(8'd200, 16'hffff);
		set_reg(CFG_PASSES, 16'd15);
		set_reg(CFG_RATE_HEBB, 16'd0);
		set_reg(CFG_PRE_DECAY, 16'd0);
		set_reg(CFG_DECAY_CA3, 16'hffff);
		set_reg(CFG_DECAY_CA1, 16'd0);
		send_op(OP_LEARN, rand_pat(), rand_pat(), 4'd0, 6'd0, 6'd0, 16'd0);

		for (int ph = 0; ph < 4; ph++) begin
			set_reg(CFG_THRESHOLD, 16'($urandom_range(0, 1024) - 512));
			set_reg(CFG_RATE_AC, 16'($urandom_range(0, 100)));
			set_reg(CFG_RATE_BC, 16'($urandom_range(0, 100)));
			set_reg(CFG_RATE_HEBB, 16'($urandom_range(0, 512)));
			set_reg(CFG_PRE_DECAY, 16'($urandom_range(0, 64)));
			set_reg(CFG_DECAY_CA3, 16'($urandom_range(0, 32)));
			set_reg(CFG_DECAY_CA1, 16'($urandom_range(0, 32)));
			set_reg(CFG_PASSES, 16'($urandom_range(1, 2)));
			calm = (ph == 3);
			if (ph == 1) begin
				@(negedge clk);
				hold_cycles = 400;
				for (int k = 0; k < 10; k++)
					send_op(OP_READ, '0, '0, MAT_31, 6'($urandom_range(0, 31)),
						6'($urandom_range(0, 31)), 16'd0);
			end
			for (int k = 0; k < 33; k++) send(rand_item());
			calm = 0;
		end

		@(negedge clk);
		in_valid <= 0;
		for (int k = 0; k < 300000 && sb.expq.size() != 0; k++) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expq.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
